### src/emgc_pkg.sv
// Package for the estimated maximum gain control block.
// Holds the payload structs, the controller/datapath command types and the constants.
// No dependencies.
package emgc_pkg;

    localparam int VAL_W         = 24;
    localparam int ADJ_W         = VAL_W + 1;
    localparam int SUM_W         = 28;
    localparam int HISTORY_LIMIT = 8;
    localparam int CNT_W         = $clog2(HISTORY_LIMIT + 1);
    localparam int DIV_STEPS     = SUM_W;
    localparam int STEP_W        = $clog2(DIV_STEPS + 1);

    localparam logic signed [VAL_W-1:0] EST_RESET = VAL_W'(2560);
    localparam logic signed [VAL_W-1:0] OBS_RESET = -VAL_W'(256000);
    localparam logic [CNT_W-1:0]        CNT_LIMIT = CNT_W'(HISTORY_LIMIT);
    localparam logic [CNT_W-1:0]        CNT_DECAY = CNT_W'(HISTORY_LIMIT / 2);

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_EOU   = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic signed [VAL_W-1:0] c0_value;
    } t_in;

    typedef struct packed {
        logic signed [ADJ_W-1:0] adjusted_c0;
        logic signed [VAL_W-1:0] current_estimate;
    } t_out;

    typedef struct packed {
        logic frame;
        logic eou_skip;
        logic start_div;
        logic finish_div;
    } t_dp_cmd;

    typedef struct packed {
        logic frame_seen;
        logic div_done;
    } t_dp_status;

endpackage

### src/emgc_dp.sv
// Datapath of the estimated maximum gain control block.
// Holds the estimate, the utterance history, a serial divider and the output register.
// Depends on emgc_pkg.
module emgc_dp
    import emgc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_in                     i_in_data,
    input  logic                    i_cfg_we,
    input  logic signed [VAL_W-1:0] i_cfg_wdata,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status,
    output t_out                    o_out_data
);

    logic signed [VAL_W-1:0] r_estimate;
    logic signed [VAL_W-1:0] r_obs_max;
    logic                    r_seen;
    logic [CNT_W-1:0]        r_count;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_neg;
    logic [SUM_W-1:0]        r_quo;
    logic [CNT_W-1:0]        r_rem;
    logic [STEP_W-1:0]       r_steps;
    t_out                    r_out;

    logic signed [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0]        n_count;
    logic [CNT_W:0]          n_shift;
    logic [CNT_W:0]          n_trial;
    logic [SUM_W-1:0]        n_quo_signed;
    logic signed [VAL_W-1:0] n_quotient;
    logic signed [SUM_W-1:0] n_half;
    logic signed [ADJ_W-1:0] n_adjusted;

    always_comb begin
        n_sum        = r_sum + SUM_W'(r_obs_max);
        n_count      = r_count + CNT_W'(1);
        n_shift      = {r_rem, r_quo[SUM_W-1]};
        n_trial      = n_shift - {1'b0, r_count};
        n_quo_signed = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
        n_quotient   = n_quo_signed[VAL_W-1:0];
        n_half       = $signed(r_sum + SUM_W'(r_sum[SUM_W-1])) >>> 1;
        n_adjusted   = ADJ_W'(i_in_data.c0_value) - ADJ_W'(r_estimate);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_estimate <= EST_RESET;
            r_obs_max  <= OBS_RESET;
            r_seen     <= 1'b0;
            r_count    <= '0;
            r_sum      <= '0;
            r_steps    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_estimate <= i_cfg_wdata;
            end
            if (i_cmd.frame) begin
                if (i_in_data.c0_value > r_obs_max) begin
                    r_obs_max <= i_in_data.c0_value;
                    r_seen    <= 1'b1;
                end
            end
            if (i_cmd.eou_skip || i_cmd.start_div) begin
                r_obs_max <= OBS_RESET;
                r_seen    <= 1'b0;
            end
            if (i_cmd.start_div) begin
                r_sum   <= n_sum;
                r_count <= n_count;
                r_steps <= STEP_W'(DIV_STEPS);
            end else if (r_steps != '0) begin
                r_steps <= r_steps - STEP_W'(1);
            end
            if (i_cmd.finish_div) begin
                r_estimate <= n_quotient;
                if (r_count == CNT_LIMIT) begin
                    r_sum   <= n_half;
                    r_count <= CNT_DECAY;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div) begin
            r_neg <= n_sum[SUM_W-1];
            r_quo <= n_sum[SUM_W-1] ? (~n_sum + SUM_W'(1)) : n_sum;
            r_rem <= '0;
        end else if (r_steps != '0) begin
            if (!n_trial[CNT_W]) begin
                r_rem <= n_trial[CNT_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= n_shift[CNT_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.frame) begin
            r_out.adjusted_c0      <= n_adjusted;
            r_out.current_estimate <= r_estimate;
        end else if (i_cmd.eou_skip) begin
            r_out.adjusted_c0      <= '0;
            r_out.current_estimate <= r_estimate;
        end else if (i_cmd.finish_div) begin
            r_out.adjusted_c0      <= '0;
            r_out.current_estimate <= n_quotient;
        end
    end

    assign o_status.frame_seen = r_seen;
    assign o_status.div_done   = (r_steps == '0);
    assign o_out_data          = r_out;

endmodule

### src/emgc_ctrl.sv
// Controller of the estimated maximum gain control block.
// Runs the handshakes, sequences the divider and owns the output valid flag.
// Depends on emgc_pkg.
module emgc_ctrl
    import emgc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_kind,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    out_free;
    logic    accept;
    t_dp_cmd n_cmd;

    always_comb begin
        out_free    = !r_out_valid || !i_out_stall;
        accept      = (r_state == S_IDLE) && i_in_valid && out_free;
        n_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_kind == KIND_FRAME) begin
                        n_cmd.frame = 1'b1;
                        n_out_valid = 1'b1;
                    end else if (i_status.frame_seen) begin
                        n_cmd.start_div = 1'b1;
                        n_state         = S_DIV;
                    end else begin
                        n_cmd.eou_skip = 1'b1;
                        n_out_valid    = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (i_status.div_done && out_free) begin
                    n_cmd.finish_div = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = n_cmd;

`ifndef SYNTHESIS
    a_accept_leads_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_out_valid || r_state == S_DIV))
        else $error("Accepted transaction produced neither a result nor a division.");
    a_finish_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_cmd.finish_div |-> (i_status.div_done && r_state == S_DIV))
        else $error("Division finished before the divider was done.");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(n_cmd))
        else $error("More than one datapath command in one cycle.");
    a_div_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_cmd.start_div |=> o_in_stall)
        else $error("Input accepted while a division is running.");
`endif

endmodule

### src/estimated_max_gain_control.sv
// Top level of the estimated maximum gain control block.
// Joins the controller and the datapath.
// Depends on emgc_pkg, emgc_ctrl and emgc_dp.
//
// A frame transaction has its result registered in the cycle after it is taken, as does an
// end-of-utterance transaction when no frame has raised the observed maximum. One that updates
// the history runs the divider: the average is formed by a restoring divider producing one
// quotient bit per cycle over the 28-bit history sum. A result is held in an output register,
// and the next input transaction is taken in the same cycle in which that result is taken.
// Writing the configuration register loads the estimate at once.
module estimated_max_gain_control
    import emgc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in                     i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out                    o_out_data,
    input  logic                    i_cfg_we,
    input  logic signed [VAL_W-1:0] i_cfg_wdata
);

    t_dp_cmd    cmd;
    t_dp_status status;

    emgc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_kind   (i_in_data.kind),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    emgc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

endmodule
